// ===== design/qnm_pkg.sv =====
`timescale 1ns / 1ps

package qnm_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int          APB_ADDR_W     = 3;
    localparam int          APB_DATA_W     = 32;
    localparam int          THR_W          = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd16;
    localparam logic [APB_ADDR_W-1:0] ADDR_ZERO_THR = 3'd0;

    localparam int N_ENTRIES = 9;

    // positive clamp: min(1.0, largest signed value)
    function automatic longint lim_pos(input int cw, input int fb);
        longint one;
        longint top;
        one = longint'(1) <<< fb;
        top = (longint'(1) <<< (cw - 1)) - 1;
        return (one < top) ? one : top;
    endfunction

    // negative clamp magnitude: min(1.0, most negative magnitude)
    function automatic longint lim_neg(input int cw, input int fb);
        longint one;
        longint top;
        one = longint'(1) <<< fb;
        top = longint'(1) <<< (cw - 1);
        return (one < top) ? one : top;
    endfunction

endpackage

// ===== design/qnm_sums.sv =====
`timescale 1ns / 1ps

module qnm_sums #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_w,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [W-1:0]  i_z,
    input  logic [15:0]          i_thr,
    output logic                 o_valid,
    output logic                 o_zero,
    output logic [2*W:0]         o_n,
    output logic [2*W+1:0]       o_rem [9],
    output logic                 o_neg [9]
);
    import qnm_pkg::*;

    localparam int PW = 2 * W;
    localparam int RW = 2 * W + 2;
    localparam int NW = 2 * W + 1;

    // stage a: products
    logic              r_va;
    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_xz <= i_x * i_z;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
            r_wy <= i_w * i_y;
            r_wz <= i_w * i_z;
        end
    end

    function automatic logic signed [RW-1:0] sx(input logic signed [PW-1:0] p);
        return {{2{p[PW-1]}}, p};
    endfunction

    // stage b: magnitude, numerators, zero test
    logic signed [RW-1:0] n_num [N_ENTRIES];
    logic signed [RW-1:0] n_nsum;
    logic [NW-1:0]        n_n;

    always_comb begin
        n_nsum   = sx(r_ww) + sx(r_xx) + sx(r_yy) + sx(r_zz);
        n_n      = n_nsum[NW-1:0];
        n_num[0] = sx(r_ww) + sx(r_xx) - sx(r_yy) - sx(r_zz);
        n_num[1] = (sx(r_xy) + sx(r_wz)) <<< 1;
        n_num[2] = (sx(r_xz) - sx(r_wy)) <<< 1;
        n_num[3] = (sx(r_xy) - sx(r_wz)) <<< 1;
        n_num[4] = sx(r_ww) + sx(r_yy) - sx(r_xx) - sx(r_zz);
        n_num[5] = (sx(r_yz) + sx(r_wx)) <<< 1;
        n_num[6] = (sx(r_xz) + sx(r_wy)) <<< 1;
        n_num[7] = (sx(r_yz) - sx(r_wx)) <<< 1;
        n_num[8] = sx(r_ww) + sx(r_zz) - sx(r_xx) - sx(r_yy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n    <= n_n;
            o_zero <= (n_n <= NW'(i_thr));
            for (int k = 0; k < N_ENTRIES; k++) begin
                o_neg[k] <= n_num[k][RW-1];
                o_rem[k] <= n_num[k][RW-1] ? RW'(-n_num[k]) : RW'(n_num[k]);
            end
        end
    end

endmodule

// ===== design/qnm_div_step.sv =====
`timescale 1ns / 1ps

module qnm_div_step #(
    parameter int W     = 16,
    parameter int QW    = 16,
    parameter bit SHIFT = 1'b1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_zero,
    input  logic [2*W:0]      i_n,
    input  logic [2*W+1:0]    i_rem [9],
    input  logic [QW-1:0]     i_q [9],
    input  logic              i_neg [9],
    output logic              o_valid,
    output logic              o_zero,
    output logic [2*W:0]      o_n,
    output logic [2*W+1:0]    o_rem [9],
    output logic [QW-1:0]     o_q [9],
    output logic              o_neg [9]
);
    import qnm_pkg::*;

    localparam int RW = 2 * W + 2;

    logic [RW-1:0] n_sh [N_ENTRIES];
    logic          n_ge [N_ENTRIES];

    always_comb begin
        for (int k = 0; k < N_ENTRIES; k++) begin
            n_sh[k] = SHIFT ? {i_rem[k][RW-2:0], 1'b0} : i_rem[k];
            n_ge[k] = (n_sh[k] >= {1'b0, i_n});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_zero <= i_zero;
            o_n    <= i_n;
            for (int k = 0; k < N_ENTRIES; k++) begin
                o_rem[k] <= n_ge[k] ? (n_sh[k] - {1'b0, i_n}) : n_sh[k];
                o_q[k]   <= {i_q[k][QW-2:0], n_ge[k]};
                o_neg[k] <= i_neg[k];
            end
        end
    end

endmodule

// ===== design/quaternion_normalize_to_matrix.sv =====
`timescale 1ns / 1ps

// quaternion to rotation matrix, fixed point
//
// input stream: one quaternion (w, x, y, z) per transaction, tdata holds
//   real_part, imag_x, imag_y, imag_z from the low bits up, COMP_WIDTH each
// output stream: nine matrix entries in tdata (r1c1, r2c1, r3c1, r1c2 ...
//   r3c3 from the low bits up), zero_magnitude in tuser
// apb port: one register, zero_threshold at byte address 0
//
// pipeline: one product stage, one sum stage, FRAC_BITS + 2 restoring
// division steps, one round stage. one transaction per cycle is accepted
// while the output is not stalled; each divider stage takes one step
// for all nine lanes (nine lanes share each stage)
//
// reset clears every valid bit and loads zero_threshold with 16
// a stall on the output freezes the whole pipeline together, so the input
// tready falls only while a finished result waits and the receiver is busy
module quaternion_normalize_to_matrix #(
    parameter int COMP_WIDTH = qnm_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qnm_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // apb
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [qnm_pkg::APB_ADDR_W-1:0]           paddr,
    input  logic [qnm_pkg::APB_DATA_W-1:0]           pwdata,
    output logic [qnm_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready,
    // input stream
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // real_part, imag_x, imag_y, imag_z
    input  logic [((4*COMP_WIDTH+7)/8)*8-1:0]        i_s_axis_tdata,
    // output stream
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // rot_r1c1, rot_r2c1, rot_r3c1, rot_r1c2, rot_r2c2, rot_r3c2,
    // rot_r1c3, rot_r2c3, rot_r3c3
    output logic [((9*COMP_WIDTH+7)/8)*8-1:0]        o_m_axis_tdata,
    // zero_magnitude
    output logic                                     o_m_axis_tuser
);
    import qnm_pkg::*;

    localparam int W      = COMP_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int RW     = 2 * W + 2;
    localparam int NW     = 2 * W + 1;
    localparam int QW     = F + 2;
    localparam int NSTEP  = F + 2;
    localparam int ODW    = ((9 * W + 7) / 8) * 8;
    localparam longint LIM_P = lim_pos(W, F);
    localparam longint LIM_N = lim_neg(W, F);

    // ---------------- configuration ----------------
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_ZERO_THR) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ZERO_THR) ? APB_DATA_W'(r_thr) : '0;

    // ---------------- pipeline control ----------------
    // all stages advance together whenever the output slot is free
    logic r_out_valid;
    logic w_en;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- products and sums ----------------
    logic              g_valid [NSTEP+1];
    logic              g_zero  [NSTEP+1];
    logic [NW-1:0]     g_n     [NSTEP+1];
    logic [RW-1:0]     g_rem   [NSTEP+1][N_ENTRIES];
    logic [QW-1:0]     g_q     [NSTEP+1][N_ENTRIES];
    logic              g_neg   [NSTEP+1][N_ENTRIES];

    qnm_sums #(.W(W)) u_sums (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_w     ($signed(i_s_axis_tdata[W-1:0])),
        .i_x     ($signed(i_s_axis_tdata[2*W-1:W])),
        .i_y     ($signed(i_s_axis_tdata[3*W-1:2*W])),
        .i_z     ($signed(i_s_axis_tdata[4*W-1:3*W])),
        .i_thr   (r_thr),
        .o_valid (g_valid[0]),
        .o_zero  (g_zero[0]),
        .o_n     (g_n[0]),
        .o_rem   (g_rem[0]),
        .o_neg   (g_neg[0])
    );

    // quotient starts empty
    always_comb begin
        for (int k = 0; k < N_ENTRIES; k++) begin
            g_q[0][k] = '0;
        end
    end

    // ---------------- restoring division, one bit per stage ----------------
    // first step takes the integer bit without a shift
    for (genvar s = 0; s < NSTEP; s++) begin : g_div
        qnm_div_step #(
            .W     (W),
            .QW    (QW),
            .SHIFT (s != 0)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (g_valid[s]),
            .i_zero  (g_zero[s]),
            .i_n     (g_n[s]),
            .i_rem   (g_rem[s]),
            .i_q     (g_q[s]),
            .i_neg   (g_neg[s]),
            .o_valid (g_valid[s+1]),
            .o_zero  (g_zero[s+1]),
            .o_n     (g_n[s+1]),
            .o_rem   (g_rem[s+1]),
            .o_q     (g_q[s+1]),
            .o_neg   (g_neg[s+1])
        );
    end

    // ---------------- round, saturate, output register ----------------
    logic [QW:0]     n_qinc [N_ENTRIES];
    logic [QW-1:0]   n_qr   [N_ENTRIES];
    logic [W-1:0]    n_ent  [N_ENTRIES];
    logic [ODW-1:0]  n_data;
    logic            n_sign;
    longint          n_mag;

    always_comb begin
        n_data = '0;
        n_sign = 1'b0;
        n_mag  = 0;
        for (int k = 0; k < N_ENTRIES; k++) begin
            // round half away from zero on the magnitude
            n_qinc[k] = {1'b0, g_q[NSTEP][k]} + (QW+1)'(1);
            n_qr[k]   = n_qinc[k][QW:1];
            n_sign    = g_neg[NSTEP][k] && (n_qr[k] != '0);
            n_mag     = longint'(n_qr[k]);
            if (n_sign) begin
                if (n_mag > LIM_N) n_mag = LIM_N;
                n_ent[k] = W'(-n_mag);
            end else begin
                if (n_mag > LIM_P) n_mag = LIM_P;
                n_ent[k] = W'(n_mag);
            end
            // identity when the magnitude counted as zero
            if (g_zero[NSTEP]) begin
                n_ent[k] = (k % 4 == 0) ? W'(LIM_P) : '0;
            end
            n_data[k*W +: W] = n_ent[k];
        end
    end

    logic [ODW-1:0] r_data;
    logic           r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= g_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
            r_user <= g_zero[NSTEP];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_user;

endmodule

// ===== bench/qnm_checker.sv =====
`timescale 1ns / 1ps

module qnm_checker #(
    parameter int CW = 16,
    parameter int FB = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [qnm_pkg::THR_W-1:0]         i_threshold,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [((4*CW+7)/8)*8-1:0]         i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [((9*CW+7)/8)*8-1:0]         i_out_data,
    input  logic                              i_out_user,
    output int                                o_errors,
    output int                                o_pending
);

    typedef struct packed {
        logic            zero_mag;
        logic [9*CW-1:0] entries;
    } matrix_t;

    matrix_t matrix_q[$];

    initial o_pending = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    // rounded, saturated num * 2^FB / n, halves away from zero
    function automatic logic [CW-1:0] ratio_entry(input longint num, input longint n);
        longint mag;
        longint q;
        longint lp;
        longint ln;
        logic   neg;
        lp  = qnm_pkg::lim_pos(CW, FB);
        ln  = qnm_pkg::lim_neg(CW, FB);
        neg = num < 0;
        mag = neg ? -num : num;
        q   = ((mag <<< (FB + 1)) / n + 1) >>> 1;
        if (neg && q != 0) begin
            if (q > ln) q = ln;
            return CW'(-q);
        end
        if (q > lp) q = lp;
        return CW'(q);
    endfunction

    function automatic matrix_t rotation_of(input logic [4*CW-1:0] d);
        longint w, x, y, z, n;
        matrix_t m;
        w = longint'($signed(d[0*CW +: CW]));
        x = longint'($signed(d[1*CW +: CW]));
        y = longint'($signed(d[2*CW +: CW]));
        z = longint'($signed(d[3*CW +: CW]));
        n = w*w + x*x + y*y + z*z;
        m = '0;
        if (n <= longint'(i_threshold)) begin
            // degenerate quaternion: identity, flagged
            m.zero_mag = 1'b1;
            for (int k = 0; k < 9; k += 4)
                m.entries[k*CW +: CW] = CW'(qnm_pkg::lim_pos(CW, FB));
            return m;
        end
        m.entries[0*CW +: CW] = ratio_entry(w*w + x*x - y*y - z*z, n);
        m.entries[1*CW +: CW] = ratio_entry(2*(x*y + w*z), n);
        m.entries[2*CW +: CW] = ratio_entry(2*(x*z - w*y), n);
        m.entries[3*CW +: CW] = ratio_entry(2*(x*y - w*z), n);
        m.entries[4*CW +: CW] = ratio_entry(w*w + y*y - x*x - z*z, n);
        m.entries[5*CW +: CW] = ratio_entry(2*(y*z + w*x), n);
        m.entries[6*CW +: CW] = ratio_entry(2*(x*z + w*y), n);
        m.entries[7*CW +: CW] = ratio_entry(2*(y*z - w*x), n);
        m.entries[8*CW +: CW] = ratio_entry(w*w + z*z - x*x - y*y, n);
        return m;
    endfunction

    always @(posedge i_clk) begin
        matrix_t want;
        if (!i_rst_n) begin
            o_errors = 0;
            matrix_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                matrix_q.push_back(rotation_of(i_in_data[4*CW-1:0]));
            if (i_out_valid && i_out_ready) begin
                if (matrix_q.size() == 0) begin
                    report_mismatch("unexpected result count", 1, 0);
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (i_out_data[k*CW +: CW] !== want.entries[k*CW +: CW])
                            report_mismatch($sformatf("entry %0d", k),
                                longint'($signed(i_out_data[k*CW +: CW])),
                                longint'($signed(want.entries[k*CW +: CW])));
                    if (i_out_user !== want.zero_mag)
                        report_mismatch("zero_magnitude", longint'(i_out_user),
                                        longint'(want.zero_mag));
                end
            end
        end
        o_pending = matrix_q.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import qnm_pkg::*;

    localparam int CW       = COMP_WIDTH_DEF;
    localparam int FB       = FRAC_BITS_DEF;
    localparam int LATENCY  = FB + 5;
    localparam int IDLE_MAX = 2000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    // real_part, imag_x, imag_y, imag_z from bit 0 up
    logic [((4*CW+7)/8)*8-1:0] s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    // rot_r1c1, rot_r2c1, rot_r3c1, rot_r1c2, rot_r2c2, rot_r3c2, rot_r1c3, rot_r2c3, rot_r3c3
    logic [((9*CW+7)/8)*8-1:0] m_data;
    // zero_magnitude
    logic                     m_user;

    // threshold as the checker should see it, updated at the write edge
    logic [THR_W-1:0]         threshold = THR_RESET;
    int                       errors;
    int                       pending;
    int                       idle_cycles = 0;
    int                       stall_mode = 0;

    always #5 i_clk = ~i_clk;

    quaternion_normalize_to_matrix #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .o_m_axis_tuser(m_user)
    );

    qnm_checker #(.CW(CW), .FB(FB)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_threshold(threshold),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_user(m_user), .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure: pattern changes every so often, including no stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog on cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_threshold(input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ZERO_THR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        threshold <= value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one transaction, valid held across back-to-back items
    task automatic send_quat(input logic [CW-1:0] w, x, y, z);
        s_valid <= 1'b1;
        s_data  <= {z, y, x, w};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic send_random(input int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
                burst = $urandom_range(1, 40);
            end
            burst--;
            case ($urandom_range(0, 5))
                // full range
                0, 1: send_quat(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
                // components within the unit range (-1.0 to just under 1.0)
                2, 3: send_quat(CW'($signed($urandom_range(0, 32767)) - 16384),
                                CW'($signed($urandom_range(0, 32767)) - 16384),
                                CW'($signed($urandom_range(0, 32767)) - 16384),
                                CW'($signed($urandom_range(0, 32767)) - 16384));
                // tiny, around the threshold
                4: send_quat(CW'($signed($urandom_range(0, 8)) - 4),
                             CW'($signed($urandom_range(0, 8)) - 4),
                             CW'($signed($urandom_range(0, 8)) - 4),
                             CW'($signed($urandom_range(0, 8)) - 4));
                // two full-range axes (w, z) with small x and y
                default: send_quat(CW'($urandom), CW'($signed($urandom_range(0, 64)) - 32),
                                   CW'($signed($urandom_range(0, 64)) - 32), CW'($urandom));
            endcase
        end
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset threshold in effect
        send_quat(0, 0, 0, 0);
        send_quat(16'sd4, 0, 0, 0);            // n exactly at threshold
        send_quat(16'sd4, 16'sd1, 0, 0);       // just above
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h8000, 0, 0, 0);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(16'sd11585, 0, 0, 16'sd11585);
        send_quat(16'sd11585, 16'h8000 + 16'sd21183, 0, 0);
        send_quat(0, 16'sd1, 16'sd1, 16'h7fff);
        s_valid <= 1'b0;
        @(posedge i_clk);
        drain();

        send_random(450);
        drain();

        write_threshold(16'd0);
        send_quat(0, 0, 0, 0);
        send_quat(16'sd1, 0, 0, 0);
        send_random(300);
        drain();

        write_threshold(16'hffff);
        send_quat(16'sd255, 16'sd10, 0, 0);
        send_quat(16'sd256, 0, 0, 0);
        send_random(300);
        drain();

        write_threshold(16'd40);
        send_random(300);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qnm_pkg.sv
design/qnm_sums.sv
design/qnm_div_step.sv
design/quaternion_normalize_to_matrix.sv
bench/qnm_checker.sv
bench/testbench.sv
